@@ rtl/proper_divisor_sum_count_macros.svh @@
// ----------------------------------------------------------------------------
// proper_divisor_sum_count assertion macros
// shared concurrent assertion forms, clocked on clk_i
// ----------------------------------------------------------------------------
`ifndef PROPER_DIVISOR_SUM_COUNT_MACROS_SVH
`define PROPER_DIVISOR_SUM_COUNT_MACROS_SVH

// checked only outside reset
`define PDSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define PDSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/pdsc_pkg.sv @@
// ----------------------------------------------------------------------------
// pdsc_pkg
// widths and limits shared by the divisor sum block and its checker
// ----------------------------------------------------------------------------
package pdsc_pkg;

  localparam int unsigned NUMBER_WIDTH_DEF = 31;
  localparam int unsigned COUNT_WIDTH      = 11;
  localparam int unsigned SUM_WIDTH        = 34;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [SUM_WIDTH-1:0]   SUM_MAX   = '1;

endpackage

@@ rtl/proper_divisor_sum_count.sv @@
// ----------------------------------------------------------------------------
// proper_divisor_sum_count
// count, sum and perfect flag of the proper divisors of one number
// ----------------------------------------------------------------------------
// Trial division: every candidate i from 1 upward is run through one shared
// restoring divider that retires one quotient bit per cycle, followed by a
// check step. The search stops at the first i whose quotient falls below i,
// so a request n tries the candidates 1 to floor(sqrt(n)) + 1 in order.
// in_ready_o is high only while no search runs; a finished result sits in the
// output register, so a new request is taken while the last result waits.
// Count and sum saturate at the output field maximum on wide settings.
// ----------------------------------------------------------------------------
module proper_divisor_sum_count #(
  parameter int unsigned NUMBER_WIDTH = pdsc_pkg::NUMBER_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [NUMBER_WIDTH-1:0]          number_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [pdsc_pkg::COUNT_WIDTH-1:0] divisor_count_o,
  output logic [pdsc_pkg::SUM_WIDTH-1:0]   divisor_sum_o,
  output logic                             is_perfect_o
);
  import pdsc_pkg::*;

  // trial divisor never exceeds 2^ceil(NUMBER_WIDTH/2)
  localparam int unsigned IW  = (NUMBER_WIDTH + 1) / 2 + 1;
  localparam int unsigned CW  = IW + 1;
  localparam int unsigned SW  = NUMBER_WIDTH + 3;
  localparam int unsigned BW  = $clog2(NUMBER_WIDTH);
  localparam int unsigned CMW = (CW > COUNT_WIDTH) ? CW : COUNT_WIDTH;
  localparam int unsigned SMW = (SW > SUM_WIDTH) ? SW : SUM_WIDTH;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DIV    = 2'd1;
  localparam logic [1:0] S_CHECK  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]              state_q, state_d;
  logic                    out_valid_q, out_valid_d;
  logic [NUMBER_WIDTH-1:0] n_q, n_d;
  logic [IW-1:0]           i_q, i_d;
  logic [IW-1:0]           rem_q, rem_d;
  logic [NUMBER_WIDTH-1:0] dq_q, dq_d;
  logic [BW-1:0]           bit_q, bit_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [SW-1:0]           sum_q, sum_d;
  logic [COUNT_WIDTH-1:0]  count_out_q, count_out_d;
  logic [SUM_WIDTH-1:0]    sum_out_q, sum_out_d;
  logic                    perfect_q, perfect_d;

  logic [IW:0]             rem_sh, rem_sub;
  logic                    rem_ge;
  logic [NUMBER_WIDTH-1:0] i_ext;
  logic                    stop, is_one, co_ne, add_i, add_co;
  logic [CMW-1:0]          cnt_ext;
  logic [SMW-1:0]          sum_ext;

  // one restoring divide step
  assign rem_sh  = {rem_q, dq_q[NUMBER_WIDTH-1]};
  assign rem_ge  = rem_sh >= {1'b0, i_q};
  assign rem_sub = rem_sh - {1'b0, i_q};

  // dq_q holds the quotient once the divide finishes
  assign i_ext  = NUMBER_WIDTH'(i_q);
  assign stop   = dq_q < i_ext;
  assign is_one = i_q == IW'(1);
  assign co_ne  = dq_q != i_ext;
  // at i == 1 the cofactor is the number itself and is left out
  assign add_i  = is_one ? co_ne : 1'b1;
  assign add_co = !is_one && co_ne;

  assign cnt_ext = CMW'(cnt_q);
  assign sum_ext = SMW'(sum_q);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    n_d         = n_q;
    i_d         = i_q;
    rem_d       = rem_q;
    dq_d        = dq_q;
    bit_d       = bit_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    count_out_d = count_out_q;
    sum_out_d   = sum_out_q;
    perfect_d   = perfect_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          n_d     = number_i;
          i_d     = IW'(1);
          dq_d    = number_i;
          rem_d   = '0;
          bit_d   = BW'(NUMBER_WIDTH - 1);
          cnt_d   = '0;
          sum_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = rem_ge ? rem_sub[IW-1:0] : rem_sh[IW-1:0];
        dq_d  = {dq_q[NUMBER_WIDTH-2:0], rem_ge};
        if (bit_q == '0) begin
          state_d = S_CHECK;
        end else begin
          bit_d = bit_q - BW'(1);
        end
      end
      S_CHECK: begin
        if (stop) begin
          state_d = S_FINISH;
        end else begin
          if (rem_q == '0) begin
            cnt_d = cnt_q + CW'(add_i) + CW'(add_co);
            sum_d = sum_q + (add_i ? SW'(i_q) : '0) + (add_co ? SW'(dq_q) : '0);
          end
          i_d     = i_q + IW'(1);
          dq_d    = n_q;
          rem_d   = '0;
          bit_d   = BW'(NUMBER_WIDTH - 1);
          state_d = S_DIV;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          count_out_d = (cnt_ext > CMW'(COUNT_MAX)) ? COUNT_MAX : cnt_ext[COUNT_WIDTH-1:0];
          sum_out_d   = (sum_ext > SMW'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_WIDTH-1:0];
          perfect_d   = (sum_q == SW'(n_q)) && (n_q != '0);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    i_q         <= i_d;
    rem_q       <= rem_d;
    dq_q        <= dq_d;
    bit_q       <= bit_d;
    cnt_q       <= cnt_d;
    sum_q       <= sum_d;
    count_out_q <= count_out_d;
    sum_out_q   <= sum_out_d;
    perfect_q   <= perfect_d;
  end

  assign in_ready_o      = state_q == S_IDLE;
  assign out_valid_o     = out_valid_q;
  assign divisor_count_o = count_out_q;
  assign divisor_sum_o   = sum_out_q;
  assign is_perfect_o    = perfect_q;

endmodule

@@ rtl/pdsc_checker.sv @@
// ----------------------------------------------------------------------------
// pdsc_assert
// port-level checks for the divisor sum block, bound to the top level
// ----------------------------------------------------------------------------
`include "proper_divisor_sum_count_macros.svh"

module pdsc_assert (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [pdsc_pkg::COUNT_WIDTH-1:0] divisor_count_o,
  input logic [pdsc_pkg::SUM_WIDTH-1:0]   divisor_sum_o,
  input logic                             is_perfect_o
);
  import pdsc_pkg::*;

  property p_out_hold;
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(divisor_count_o) && $stable(divisor_sum_o) &&
      $stable(is_perfect_o);
  endproperty

  property p_perfect_count;
    out_valid_o && is_perfect_o |-> divisor_count_o > COUNT_WIDTH'(1);
  endproperty

  // a stalled result keeps its fields
  `PDSC_ASSERT(a_out_hold, p_out_hold, "result changed while stalled")

  // a taken request starts a search, so the input side closes
  `PDSC_ASSERT(a_busy_after_req, in_valid_i && in_ready_o |=> !in_ready_o, "ready stayed high")

  // only numbers up to one have no proper divisors, and then the sum is zero too
  `PDSC_ASSERT(a_count_sum_zero, out_valid_o |-> ((divisor_count_o == '0) == (divisor_sum_o == '0)), "zero mismatch")

  `PDSC_ASSERT(a_perfect_nonzero, p_perfect_count, "perfect flag with too few divisors")

  // the edge after a reset edge shows no result
  `PDSC_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o, "result valid after reset")

endmodule

bind proper_divisor_sum_count pdsc_assert u_pdsc_assert (.*);
